// File: rtl/core/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared widths, codes and types for the handle slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

    localparam int CNT_W         = 7;
    localparam int ID_W          = 32;
    localparam int WORD_W        = 32;
    localparam int SIDX_W        = 6;
    localparam int ACT_W         = 2;
    localparam int DEF_MAX_SLOTS = 64;
    localparam int CAP_FIELD_MAX = (2 ** CNT_W) - 1;

    localparam logic [ID_W-1:0]  FREE_ID   = '1;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_LOOKUP  = 2'd2,
        ACT_COMPACT = 2'd3
    } action_t;

    typedef struct packed {
        logic id;
        logic word;
    } slot_wr_en_t;

endpackage

`default_nettype wire

// File: rtl/core/hsa_slot_store.sv
// ----------------------------------------------------------------------------
// hsa_slot_store
// Slot table: id and user word per slot, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_slot_store
    import hsa_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SLOTS,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire slot_wr_en_t       wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [ID_W-1:0]   wr_id,
    input  wire logic [WORD_W-1:0] wr_word,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [ID_W-1:0]   rd_id,
    output logic      [WORD_W-1:0] rd_word
);

    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [WORD_W-1:0] word_mem [DEPTH];
    logic [ID_W-1:0]   rd_id_reg;
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.id)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (wr_en.word)
        begin
            word_mem[wr_addr] <= wr_word;
        end
        rd_id_reg   <= id_mem[rd_addr];
        rd_word_reg <= word_mem[rd_addr];
    end

    assign rd_id   = rd_id_reg;
    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

// File: rtl/core/handle_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// handle_slot_allocator_top
// Fixed slot pool with handle ids: allocate, free, lookup and compact.
// ----------------------------------------------------------------------------
// Allocate, free and lookup walk the slot table through its one read port:
// busy while the walk runs, and done strobes in the cycle that busy drops.
// Full pool or an all-ones handle fails at once (done in the next cycle).
// Compact moves tail entries down into free slots, then trims in_use_slots. One request at a time.
// Reset clears counts, id counter and sequencer; capacity resets to 64.
// The slot table needs no clearing pass. done cannot be stalled.
`default_nettype none

module handle_slot_allocator_top
    import hsa_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [ID_W-1:0]   handle_id,
    input  wire logic [WORD_W-1:0] user_word,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_data,
    output logic                   done,
    output logic                   ok,
    output logic      [ID_W-1:0]   new_handle,
    output logic      [SIDX_W-1:0] slot_index,
    output logic      [WORD_W-1:0] slot_user_word,
    output logic      [CNT_W-1:0]  occupied,
    output logic      [CNT_W-1:0]  in_use_slots,
    output logic                   is_empty,
    output logic                   is_full
);

    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CAP_LIMIT = (MAX_SLOTS > CAP_FIELD_MAX) ? CAP_FIELD_MAX : MAX_SLOTS;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CTEST,
        S_CCHKI,
        S_CTESTJ,
        S_CCHKJ,
        S_CCLR
    } state_t;

    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [ID_W-1:0]   target_reg, target_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]  ci_reg, ci_next;
    logic [CNT_W-1:0]  cj_reg, cj_next;
    logic [CNT_W-1:0]  slot_count_reg, slot_count_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [ID_W-1:0]   id_ctr_reg, id_ctr_next;
    logic [CNT_W-1:0]  cap_reg;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [ID_W-1:0]   nh_reg, nh_next;
    logic [SIDX_W-1:0] sidx_reg, sidx_next;
    logic [WORD_W-1:0] sword_reg, sword_next;

    slot_wr_en_t       wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ID_W-1:0]   wr_id;
    logic [WORD_W-1:0] wr_word;
    logic [IDX_W-1:0]  rd_addr;
    logic [ID_W-1:0]   rd_id;
    logic [WORD_W-1:0] rd_word;

    logic [CNT_W-1:0]  cap_eff;
    logic [ID_W-1:0]   id_inc;
    logic [ID_W-1:0]   new_id;
    logic              match;
    logic              issuing;

    hsa_slot_store #(
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_word (wr_word),
        .rd_addr (rd_addr),
        .rd_id   (rd_id),
        .rd_word (rd_word)
    );

    assign cap_eff = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    assign id_inc  = id_ctr_reg + ID_W'(1);
    assign new_id  = (id_inc == FREE_ID) ? '0 : id_inc;
    // shared compare: table id against the request target
    assign match   = (rd_id == target_reg);
    assign issuing = (issue_reg < slot_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        target_next     = target_reg;
        word_next       = word_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        ci_next         = ci_reg;
        cj_next         = cj_reg;
        slot_count_next = slot_count_reg;
        occ_next        = occ_reg;
        id_ctr_next     = id_ctr_reg;
        done_next       = 1'b0;
        ok_next         = ok_reg;
        nh_next         = nh_reg;
        sidx_next       = sidx_reg;
        sword_next      = sword_reg;
        wr_en           = '0;
        wr_addr         = IDX_W'(pend_idx_reg);
        wr_id           = FREE_ID;
        wr_word         = word_reg;
        rd_addr         = IDX_W'(issue_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next        = action_t'(action);
                    word_next       = user_word;
                    issue_next      = '0;
                    pend_valid_next = 1'b0;
                    ok_next         = 1'b0;
                    nh_next         = FREE_ID;
                    sidx_next       = '0;
                    sword_next      = '0;
                    case (action_t'(action))
                        ACT_ALLOC:
                        begin
                            target_next = FREE_ID;
                            if (occ_reg >= cap_eff)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_FREE, ACT_LOOKUP:
                        begin
                            target_next = handle_id;
                            if (handle_id == FREE_ID)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_COMPACT:
                        begin
                            target_next = FREE_ID;
                            ok_next     = 1'b1;
                            if (slot_count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ci_next    = '0;
                                cj_next    = slot_count_reg - CNT_W'(1);
                                state_next = S_CTEST;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                pend_valid_next = issuing;
                pend_idx_next   = issue_reg;
                if (issuing)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_valid_reg && match)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    ok_next    = 1'b1;
                    case (act_reg)
                        ACT_ALLOC:
                        begin
                            wr_en       = '{id: 1'b1, word: 1'b1};
                            wr_id       = new_id;
                            id_ctr_next = new_id;
                            occ_next    = occ_reg + CNT_W'(1);
                            nh_next     = new_id;
                            sidx_next   = pend_idx_reg[SIDX_W-1:0];
                            sword_next  = word_reg;
                        end
                        ACT_FREE:
                        begin
                            wr_en.id = 1'b1;
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            sidx_next  = pend_idx_reg[SIDX_W-1:0];
                            sword_next = rd_word;
                        end
                    endcase
                end
                else if (!pend_valid_reg && !issuing)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    // no free slot in use: append when room is left
                    if (act_reg == ACT_ALLOC && slot_count_reg < cap_eff)
                    begin
                        wr_en           = '{id: 1'b1, word: 1'b1};
                        wr_addr         = IDX_W'(slot_count_reg);
                        wr_id           = new_id;
                        id_ctr_next     = new_id;
                        occ_next        = occ_reg + CNT_W'(1);
                        slot_count_next = slot_count_reg + CNT_W'(1);
                        ok_next         = 1'b1;
                        nh_next         = new_id;
                        sidx_next       = slot_count_reg[SIDX_W-1:0];
                        sword_next      = word_reg;
                    end
                end
            end

            S_CTEST:
            begin
                rd_addr = IDX_W'(ci_reg);
                if (ci_reg < cj_reg)
                begin
                    state_next = S_CCHKI;
                end
                else
                begin
                    slot_count_next = occ_reg;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_CCHKI:
            begin
                if (!match)
                begin
                    ci_next    = ci_reg + CNT_W'(1);
                    state_next = S_CTEST;
                end
                else
                begin
                    state_next = S_CTESTJ;
                end
            end

            S_CTESTJ:
            begin
                rd_addr = IDX_W'(cj_reg);
                if (cj_reg > ci_reg)
                begin
                    state_next = S_CCHKJ;
                end
                else
                begin
                    slot_count_next = occ_reg;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_CCHKJ:
            begin
                if (!match)
                begin
                    wr_en      = '{id: 1'b1, word: 1'b1};
                    wr_addr    = IDX_W'(ci_reg);
                    wr_id      = rd_id;
                    wr_word    = rd_word;
                    state_next = S_CCLR;
                end
                else
                begin
                    cj_next    = cj_reg - CNT_W'(1);
                    state_next = S_CTESTJ;
                end
            end

            S_CCLR:
            begin
                wr_en.id   = 1'b1;
                wr_addr    = IDX_W'(cj_reg);
                ci_next    = ci_reg + CNT_W'(1);
                state_next = S_CTEST;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_ALLOC;
            issue_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            ci_reg         <= '0;
            cj_reg         <= '0;
            slot_count_reg <= '0;
            occ_reg        <= '0;
            id_ctr_reg     <= '0;
            cap_reg        <= CAP_RESET;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            nh_reg         <= FREE_ID;
            sidx_reg       <= '0;
            sword_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            ci_reg         <= ci_next;
            cj_reg         <= cj_next;
            slot_count_reg <= slot_count_next;
            occ_reg        <= occ_next;
            id_ctr_reg     <= id_ctr_next;
            done_reg       <= done_next;
            ok_reg         <= ok_next;
            nh_reg         <= nh_next;
            sidx_reg       <= sidx_next;
            sword_reg      <= sword_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        word_reg   <= word_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign new_handle     = nh_reg;
    assign slot_index     = sidx_reg;
    assign slot_user_word = sword_reg;
    assign occupied       = occ_reg;
    assign in_use_slots   = slot_count_reg;
    assign is_empty       = (occ_reg == '0);
    assign is_full        = (occ_reg >= cap_eff);

endmodule

`default_nettype wire

// File: sim/tb_handle_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_slot_allocator_top
// Self-checking bench for the handle slot allocator. A shadow pool model is
// stepped twice: once while the request list is built, to aim frees and
// lookups at live handles, and once as requests are accepted, to predict
// every result, which is then checked field by field when done strobes.
// ----------------------------------------------------------------------------

module tb_handle_slot_allocator_top;
    import hsa_pkg::*;

    localparam int PLAN     = 0;
    localparam int MODEL    = 1;
    localparam int WATCHDOG = 5000;
    localparam int TAIL     = 400;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_SETTLE
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        action_t            act;
        logic [ID_W-1:0]    handle;
        logic [WORD_W-1:0]  word;
        logic [CNT_W-1:0]   cap;
        logic [6:0]         idle_pct;
    } step_t;

    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    new_handle;
        logic [SIDX_W-1:0]  slot_index;
        logic [WORD_W-1:0]  slot_user_word;
        logic [CNT_W-1:0]   occupied;
        logic [CNT_W-1:0]   in_use_slots;
        logic               is_empty;
        logic               is_full;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [ACT_W-1:0]    action = '0;
    logic [ID_W-1:0]     handle_id = '0;
    logic [WORD_W-1:0]   user_word = '0;
    logic                cfg_valid = 1'b0;
    logic [CNT_W-1:0]    cfg_data = '0;
    logic                busy;
    logic                cfg_ready;
    logic                done;
    logic                ok;
    logic [ID_W-1:0]     new_handle;
    logic [SIDX_W-1:0]   slot_index;
    logic [WORD_W-1:0]   slot_user_word;
    logic [CNT_W-1:0]    occupied;
    logic [CNT_W-1:0]    in_use_slots;
    logic                is_empty;
    logic                is_full;

    // shadow pools: PLAN follows the request list, MODEL follows the DUT
    logic [ID_W-1:0]     slot_id   [2][DEF_MAX_SLOTS];
    logic [WORD_W-1:0]   slot_word [2][DEF_MAX_SLOTS];
    int unsigned         in_use    [2];
    int unsigned         live      [2];
    logic [ID_W-1:0]     id_ctr    [2];
    logic [CNT_W-1:0]    cap_reg   [2];

    step_t               op_queue  [$];
    outcome_t            outcome_q [$];
    int unsigned         n_items;
    int unsigned         n_errors;
    int unsigned         n_req_sent, n_req_taken;
    int unsigned         n_cfg_sent, n_cfg_taken;
    int unsigned         quiet_cycles;
    logic                req_open, cfg_open;
    logic [6:0]          idle_now;

    handle_slot_allocator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .handle_id      (handle_id),
        .user_word      (user_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .ok             (ok),
        .new_handle     (new_handle),
        .slot_index     (slot_index),
        .slot_user_word (slot_user_word),
        .occupied       (occupied),
        .in_use_slots   (in_use_slots),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // pool model
    // ------------------------------------------------------------------
    function automatic bit holds(input int k, input int unsigned i);
        return i < in_use[k] && slot_id[k][i] != FREE_ID;
    endfunction

    function automatic int find_id(input int k, input logic [ID_W-1:0] h);
        int s;
        s = -1;
        if (h != FREE_ID)
            for (int i = in_use[k] - 1; i >= 0; i--)
                if (slot_id[k][i] == h)
                    s = i;
        return s;
    endfunction

    function automatic void squeeze(input int k);
        int unsigned i, j;
        if (in_use[k] != 0)
        begin
            i = 0;
            j = in_use[k] - 1;
            while (i < j)
            begin
                if (holds(k, i))
                    i++;
                else
                begin
                    while (j > i && !holds(k, j))
                        j--;
                    if (j > i)
                    begin
                        slot_id[k][i]   = slot_id[k][j];
                        slot_word[k][i] = slot_word[k][j];
                        slot_id[k][j]   = FREE_ID;
                        i++;
                    end
                end
            end
            in_use[k] = live[k];
        end
    endfunction

    function automatic outcome_t pool_step(input int k, input action_t act,
                                           input logic [ID_W-1:0] h,
                                           input logic [WORD_W-1:0] w);
        outcome_t        r;
        int unsigned     lim;
        int              s;
        logic [ID_W-1:0] nid;
        lim = (cap_reg[k] > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : cap_reg[k];
        r = '0;
        r.new_handle = FREE_ID;
        case (act)
            ACT_ALLOC:
            begin
                if (live[k] < lim)
                begin
                    s = -1;
                    for (int i = in_use[k] - 1; i >= 0; i--)
                        if (slot_id[k][i] == FREE_ID)
                            s = i;
                    if (s < 0 && in_use[k] < lim && in_use[k] < DEF_MAX_SLOTS)
                    begin
                        s = in_use[k];
                        in_use[k]++;
                    end
                    if (s >= 0)
                    begin
                        nid = id_ctr[k] + 1;
                        if (nid == FREE_ID)
                            nid = '0;
                        id_ctr[k]       = nid;
                        slot_id[k][s]   = nid;
                        slot_word[k][s] = w;
                        live[k]++;
                        r.ok             = 1'b1;
                        r.new_handle     = nid;
                        r.slot_index     = SIDX_W'(s);
                        r.slot_user_word = w;
                    end
                end
            end
            ACT_FREE:
            begin
                s = find_id(k, h);
                if (s >= 0)
                begin
                    slot_id[k][s] = FREE_ID;
                    if (live[k] > 0)
                        live[k]--;
                    r.ok = 1'b1;
                end
            end
            ACT_LOOKUP:
            begin
                s = find_id(k, h);
                if (s >= 0)
                begin
                    r.ok             = 1'b1;
                    r.slot_index     = SIDX_W'(s);
                    r.slot_user_word = slot_word[k][s];
                end
            end
            default:
            begin
                squeeze(k);
                r.ok = 1'b1;
            end
        endcase
        r.occupied     = CNT_W'(live[k]);
        r.in_use_slots = CNT_W'(in_use[k]);
        r.is_empty     = (live[k] == 0);
        r.is_full      = (live[k] >= lim);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request list
    // ------------------------------------------------------------------
    task automatic add_req(input action_t a, input logic [ID_W-1:0] h,
                           input logic [WORD_W-1:0] w);
        step_t s;
        s = '0;
        s.kind     = STEP_REQ;
        s.act      = a;
        s.handle   = h;
        s.word     = w;
        s.idle_pct = idle_now;
        void'(pool_step(PLAN, a, h, w));
        op_queue.push_back(s);
        n_items++;
    endtask

    task automatic add_cap(input logic [CNT_W-1:0] v);
        step_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.cap  = v;
        cap_reg[PLAN] = v;
        op_queue.push_back(s);
    endtask

    task automatic add_settle();
        step_t s;
        s = '0;
        s.kind = STEP_SETTLE;
        op_queue.push_back(s);
    endtask

    function automatic logic [ID_W-1:0] pick_live();
        logic [ID_W-1:0] held [$];
        for (int i = 0; i < in_use[PLAN]; i++)
            if (slot_id[PLAN][i] != FREE_ID)
                held.push_back(slot_id[PLAN][i]);
        if (held.size() == 0)
            return $urandom();
        return held[$urandom_range(held.size() - 1)];
    endfunction

    function automatic logic [ID_W-1:0] pick_stray();
        case ($urandom_range(2))
            0:       return $urandom();
            1:       return FREE_ID;
            default: return id_ctr[PLAN] - $urandom_range(4);
        endcase
    endfunction

    task automatic add_random_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            add_req(ACT_ALLOC, $urandom(), $urandom());
        else if (r < 58)
            add_req(ACT_FREE, pick_live(), $urandom());
        else if (r < 76)
            add_req(ACT_LOOKUP, pick_live(), $urandom());
        else if (r < 82)
            add_req(ACT_FREE, pick_stray(), $urandom());
        else if (r < 90)
            add_req(ACT_LOOKUP, pick_stray(), $urandom());
        else
            add_req(ACT_COMPACT, $urandom(), $urandom());
    endtask

    function automatic logic [CNT_W-1:0] pick_cap();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return CNT_W'(2);
            3, 4:    return CNT_W'(64);
            5:       return CNT_W'(CAP_FIELD_MAX);
            6:       return CNT_W'($urandom_range(65, 126));
            default: return CNT_W'($urandom_range(3, 63));
        endcase
    endfunction

    initial
    begin
        int unsigned target, lim, n;
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < DEF_MAX_SLOTS; i++)
            begin
                slot_id[k][i]   = FREE_ID;
                slot_word[k][i] = '0;
            end
            in_use[k]  = 0;
            live[k]    = 0;
            id_ctr[k]  = '0;
            cap_reg[k] = CAP_RESET;
        end
        n_items = 0;
        n_errors = 0;
        n_req_sent = 0;
        n_req_taken = 0;
        n_cfg_sent = 0;
        n_cfg_taken = 0;
        quiet_cycles = 0;
        req_open = 1'b0;
        cfg_open = 1'b0;
        idle_now = 7'd19;

        // empty pool, no-handle, stale handle, holes, compaction
        add_req(ACT_LOOKUP, '0, $urandom());
        add_req(ACT_FREE, FREE_ID, $urandom());
        add_req(ACT_COMPACT, $urandom(), $urandom());
        add_req(ACT_ALLOC, '0, '0);
        add_req(ACT_ALLOC, '0, '1);
        add_req(ACT_ALLOC, FREE_ID, 32'hA5A5_5A5A);
        add_req(ACT_LOOKUP, 32'd1, $urandom());
        add_req(ACT_LOOKUP, FREE_ID, $urandom());
        add_req(ACT_FREE, 32'd1, $urandom());
        add_req(ACT_FREE, 32'd1, $urandom());
        add_req(ACT_LOOKUP, 32'd1, $urandom());
        add_req(ACT_LOOKUP, 32'd3, $urandom());
        add_req(ACT_COMPACT, $urandom(), $urandom());
        add_req(ACT_LOOKUP, 32'd3, $urandom());
        add_req(ACT_ALLOC, $urandom(), $urandom());
        // capacity below occupancy, then zero, then above the built depth
        add_cap(CNT_W'(1));
        add_req(ACT_ALLOC, $urandom(), $urandom());
        add_req(ACT_FREE, 32'd2, $urandom());
        add_req(ACT_FREE, 32'd3, $urandom());
        add_req(ACT_ALLOC, $urandom(), $urandom());
        add_req(ACT_FREE, 32'd4, $urandom());
        add_req(ACT_ALLOC, $urandom(), $urandom());
        add_req(ACT_ALLOC, $urandom(), $urandom());
        add_cap('0);
        add_req(ACT_ALLOC, $urandom(), $urandom());
        add_req(ACT_COMPACT, $urandom(), $urandom());
        add_cap(CNT_W'(CAP_FIELD_MAX));
        add_req(ACT_LOOKUP, pick_live(), $urandom());
        add_settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_now = (ph == 0) ? 7'd19 : (ph == 1) ? 7'd82 : 7'd0;
            target = n_items + 250;
            while (n_items < target)
            begin
                add_cap(pick_cap());
                if ($urandom_range(2) == 0)
                begin
                    lim = (cap_reg[PLAN] > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : cap_reg[PLAN];
                    n = (live[PLAN] > lim) ? 1 : lim - live[PLAN] + 1;
                    repeat (n) add_req(ACT_ALLOC, $urandom(), $urandom());
                end
                repeat ($urandom_range(20, 50)) add_random_op();
                if ($urandom_range(3) == 0)
                    add_settle();
            end
        end

        while (op_queue.size() != 0 || req_open || cfg_open || outcome_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        step_t              s;
        logic               go_req, go_cfg, new_req;
        logic [ACT_W-1:0]   a_nx;
        logic [ID_W-1:0]    h_nx;
        logic [WORD_W-1:0]  w_nx;
        go_req  = 1'b0;
        go_cfg  = 1'b0;
        new_req = 1'b0;
        a_nx    = ACT_W'($urandom());
        h_nx    = $urandom();
        w_nx    = $urandom();
        if (rst_n)
        begin
            if (req_open && n_req_taken == n_req_sent)
                req_open = 1'b0;
            if (cfg_open && n_cfg_taken == n_cfg_sent)
                cfg_open = 1'b0;
            if (req_open)
                go_req = 1'b1;
            else if (cfg_open)
                go_cfg = 1'b1;
            else if (op_queue.size() != 0)
            begin
                s = op_queue[0];
                case (s.kind)
                    STEP_REQ:
                    begin
                        if ($urandom_range(99) >= s.idle_pct)
                        begin
                            void'(op_queue.pop_front());
                            go_req   = 1'b1;
                            new_req  = 1'b1;
                            a_nx     = s.act;
                            h_nx     = s.handle;
                            w_nx     = s.word;
                            req_open = 1'b1;
                            n_req_sent++;
                        end
                    end
                    STEP_CFG:
                    begin
                        // only with the pool idle and every result back
                        if (outcome_q.size() == 0 && !busy)
                        begin
                            if (quiet_cycles < 4)
                                quiet_cycles++;
                            else
                            begin
                                void'(op_queue.pop_front());
                                quiet_cycles = 0;
                                go_cfg   = 1'b1;
                                cfg_data <= s.cap;
                                cfg_open = 1'b1;
                                n_cfg_sent++;
                            end
                        end
                        else
                            quiet_cycles = 0;
                    end
                    default:
                    begin
                        if (outcome_q.size() == 0)
                            void'(op_queue.pop_front());
                    end
                endcase
            end
            start     <= go_req;
            cfg_valid <= go_cfg;
            if (new_req || !go_req)
            begin
                action    <= a_nx;
                handle_id <= h_nx;
                user_word <= w_nx;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            n_errors++;
        end
    endtask

    int unsigned stall_cycles = 0;

    always @(posedge clk)
    begin
        outcome_t want;
        logic     hit;
        hit = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                hit = 1'b1;
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: stray result, expected none, actual ok=%0b handle=0x%0h",
                             $time, ok, new_handle);
                    n_errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("ok", want.ok, ok);
                    check_field("new_handle", want.new_handle, new_handle);
                    check_field("slot_index", want.slot_index, slot_index);
                    check_field("slot_user_word", want.slot_user_word, slot_user_word);
                    check_field("occupied", want.occupied, occupied);
                    check_field("in_use_slots", want.in_use_slots, in_use_slots);
                    check_field("is_empty", want.is_empty, is_empty);
                    check_field("is_full", want.is_full, is_full);
                end
            end
            if (start && !busy)
            begin
                hit = 1'b1;
                outcome_q.push_back(pool_step(MODEL, action_t'(action), handle_id, user_word));
                n_req_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                hit = 1'b1;
                cap_reg[MODEL] = cfg_data;
                n_cfg_taken++;
            end
            stall_cycles = hit ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
rtl/core/hsa_pkg.sv
rtl/core/hsa_slot_store.sv
rtl/core/handle_slot_allocator_top.sv
sim/tb_handle_slot_allocator_top.sv
